### design/b64e_pkg.sv
// Shared types, constants and the character mapping function of the Base64 encoder.
`default_nettype none
package b64e_pkg;

	// Depth of the group queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// ASCII code of the pad character
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// One three-byte group as handed from front to back
	typedef struct packed {
		logic [23:0] bytes;   // first byte in bits 23..16, zero filled
		logic [1:0]  phase;   // bytes in the group minus one
		logic        eom;     // group closes the message
	} group_t;

	// Map a six-bit value onto the standard alphabet
	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] w;
		logic [7:0] c;
		w = {2'b00, v};
		if (v < 6'd26) begin
			c = w + 8'd65;
		end else if (v < 6'd52) begin
			c = w + 8'd71;
		end else if (v < 6'd62) begin
			c = w - 8'd4;
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### design/b64e_front.sv
// Front part: gathers input bytes into groups of three and pushes closed groups.
`default_nettype none
module b64e_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [7:0]          in_byte,
	input  wire                 in_eom,
	input  wire                 queue_full,
	output logic                push,
	output b64e_pkg::group_t    push_group
);
	import b64e_pkg::*;

	logic [1:0]  phase_q;
	logic [15:0] held_q;
	logic        accept;
	logic        close;
	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [7:0]  b2;

	// Every item needs a free queue slot in case it closes a group
	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign close    = (phase_q == 2'd2) || in_eom;

	// Place the new byte behind the held ones
	always_comb begin
		b0 = 8'h00;
		b1 = 8'h00;
		b2 = 8'h00;
		case (phase_q)
			2'd1: begin
				b0 = held_q[15:8];
				b1 = in_byte;
			end
			2'd2: begin
				b0 = held_q[15:8];
				b1 = held_q[7:0];
				b2 = in_byte;
			end
			default: begin
				b0 = in_byte;
			end
		endcase
	end

	assign push             = accept && close;
	assign push_group.bytes = {b0, b1, b2};
	assign push_group.phase = (phase_q == 2'd3) ? 2'd0 : phase_q;
	assign push_group.eom   = in_eom;

	// Group phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
		end else if (accept) begin
			if (close) begin
				phase_q <= 2'd0;
			end else begin
				phase_q <= push_group.phase + 2'd1;
			end
		end
	end

	// Held bytes of an open group
	always_ff @(posedge clk) begin
		if (accept && !close) begin
			held_q <= {b0, b1};
		end
	end

endmodule
`default_nettype wire

### design/b64e_queue.sv
// Short queue of closed groups between front and back.
`default_nettype none
module b64e_queue #(
	parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  b64e_pkg::group_t    push_group,
	input  wire                 pop,
	output b64e_pkg::group_t    head,
	output logic                empty,
	output logic                full
);
	import b64e_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	group_t          slots_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == FULL_CNT);
	assign head  = slots_q[rd_q];

	// Slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_group;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_SLOT) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_SLOT) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### design/b64e_back.sv
// Back part: turns the queued group into four characters, one per cycle unless stalled.
`default_nettype none
module b64e_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  b64e_pkg::group_t    head,
	input  wire                 empty,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [7:0]          out_char,
	output logic                out_last
);
	import b64e_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       advance;
	logic [5:0] sextet;
	logic       is_pad;
	logic [7:0] next_char;

	// Output slot frees when empty or taken this cycle
	assign advance = !empty && (!valid_q || out_ready);
	assign pop     = advance && (idx_q == 2'd3);

	// Pick the six bits of the current character
	always_comb begin
		case (idx_q)
			2'd0:    sextet = head.bytes[23:18];
			2'd1:    sextet = head.bytes[17:12];
			2'd2:    sextet = head.bytes[11:6];
			default: sextet = head.bytes[5:0];
		endcase
	end

	assign is_pad    = {1'b0, idx_q} > ({1'b0, head.phase} + 3'd1);
	assign next_char = is_pad ? PAD_CHAR : sextet_char(sextet);

	// Character index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q   <= idx_q + 2'd1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			char_q <= next_char;
			last_q <= head.eom && (idx_q == 2'd3);
		end
	end

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

endmodule
`default_nettype wire

### design/base64_encoder.sv
// Top level of the streaming Base64 encoder.
// Takes one byte per item, tlast on the final byte of a message, and gives
// one ASCII character per item of the standard alphabet with '=' padding; tlast
// marks the final character. Input is taken every cycle while the group queue
// has room; the output port gives one character per cycle while m_tready takes it.
// With the back part idle, a group that closes is first written into the queue,
// and its first character is then registered in the back part's output slot.
`default_nettype none
module base64_encoder #(
	parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] data_byte
	input  wire         s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_char
	output logic        m_tlast    // last_char
);
	import b64e_pkg::*;

	logic   queue_full;
	logic   queue_empty;
	logic   push;
	logic   pop;
	group_t push_group;
	group_t head;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_eom     (s_tlast),
		.queue_full (queue_full),
		.push       (push),
		.push_group (push_group)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.pop        (pop),
		.head       (head),
		.empty      (queue_empty),
		.full       (queue_full)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (queue_empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
`default_nettype wire

### design/b64e_checker.sv
// Port checker of the Base64 encoder and its bind to the top level.
`default_nettype none
module b64e_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       m_tvalid,
	input wire       m_tready,
	input wire [7:0] m_tdata,
	input wire       m_tlast
);
	import b64e_pkg::*;

	// A stalled item stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped under stall");

	// A stalled item keeps its payload
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output payload changed under stall");

	// Every character is from the alphabet or the pad
	a_alphabet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata >= 8'h41 && m_tdata <= 8'h5A)
			|| (m_tdata >= 8'h61 && m_tdata <= 8'h7A)
			|| (m_tdata >= 8'h30 && m_tdata <= 8'h39)
			|| m_tdata == 8'h2B || m_tdata == 8'h2F || m_tdata == PAD_CHAR)
		else $error("character outside the alphabet");

	// Padding runs to the end of the message
	a_pad_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tdata == PAD_CHAR && !m_tlast
			|=> !m_tvalid || m_tdata == PAD_CHAR)
		else $error("character after a pad");

	// A valid character right after a pad that did not end the message is a pad too
	a_last_pad: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_tvalid && m_tready && m_tdata == PAD_CHAR && !m_tlast)
			&& m_tvalid |-> m_tdata == PAD_CHAR)
		else $error("pad run broken");

endmodule

bind base64_encoder b64e_checker u_b64e_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire
